FILE: design/scfla_pkg.sv
// Shared types and constants for the size class free list allocator.
// Holds status codes, controller states, and the command and status structs
// that join the controller to the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scfla_pkg;

   localparam int DEF_ARENA_BYTES   = 65536;
   localparam int DEF_REFILL_CHUNKS = 8;

   localparam int NUM_CLASSES = 6;
   localparam int CLASS_W     = 3;
   localparam int ADDR_W      = 16;
   localparam int LINK_W      = 17;
   localparam int LINK_DEPTH  = 16384;
   localparam int LINK_AW     = $clog2(LINK_DEPTH);
   localparam int ADDR_SPACE  = 65536;

   localparam logic [LINK_W-1:0] EMPTY_MARK = 17'h10000;
   localparam logic [15:0]       MAX_POOLED = 16'd128;
   localparam logic [7:0]        CHUNK_MIN  = 8'd4;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      RS_OK         = 2'd0,
      RS_NOT_POOLED = 2'd1,
      RS_IGNORED    = 2'd2,
      RS_EXHAUSTED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP,
      S_REFILL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic capture_req;
      logic latch_pend;
      logic push;
      logic pop_read;
      logic pop_commit;
      logic refill_start;
      logic refill_write;
      logic refill_commit;
      logic load_rsp;
      logic load_src_exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic do_push;
      logic do_pop;
      logic do_refill;
      logic refill_last;
      logic slot_free;
   } dp_status_type;

   function automatic logic [CLASS_W-1:0] class_of(input logic [15:0] size);
      logic [CLASS_W-1:0] c;
      if (size <= 16'd4) c = 3'd0;
      else if (size <= 16'd8) c = 3'd1;
      else if (size <= 16'd16) c = 3'd2;
      else if (size <= 16'd32) c = 3'd3;
      else if (size <= 16'd64) c = 3'd4;
      else c = 3'd5;
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/scfla_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for the link store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scfla_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/scfla_ctrl.sv
// Controller state machine for the allocator.
// Sequences accept, execute, pop, refill and response; uses scfla_pkg types.
`timescale 1ns / 1ps
`default_nettype none

module scfla_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire scfla_pkg::dp_status_type st,
   output scfla_pkg::ctrl_cmd_type       cmd
);

   scfla_pkg::state_type state_ff;
   scfla_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scfla_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         scfla_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture_req = 1'b1;
               state_in        = scfla_pkg::S_EXEC;
            end
         end
         scfla_pkg::S_EXEC: begin
            cmd.latch_pend = 1'b1;
            priority if (st.do_pop) begin
               cmd.pop_read = 1'b1;
               state_in     = scfla_pkg::S_POP;
            end else if (st.do_refill) begin
               cmd.refill_start = 1'b1;
               state_in         = scfla_pkg::S_REFILL;
            end else begin
               cmd.push = st.do_push;
               if (st.slot_free) begin
                  cmd.load_rsp      = 1'b1;
                  cmd.load_src_exec = 1'b1;
                  state_in          = scfla_pkg::S_IDLE;
               end else begin
                  state_in = scfla_pkg::S_RESP;
               end
            end
         end
         scfla_pkg::S_POP: begin
            cmd.pop_commit = 1'b1;
            if (st.slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = scfla_pkg::S_IDLE;
            end else begin
               state_in = scfla_pkg::S_RESP;
            end
         end
         scfla_pkg::S_REFILL: begin
            cmd.refill_write = 1'b1;
            if (st.refill_last) begin
               cmd.refill_commit = 1'b1;
               if (st.slot_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = scfla_pkg::S_IDLE;
               end else begin
                  state_in = scfla_pkg::S_RESP;
               end
            end
         end
         scfla_pkg::S_RESP: begin
            if (st.slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = scfla_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = scfla_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/scfla_datapath.sv
// Datapath for the allocator: request register, class heads, bump pointer,
// refill walker, link store and output register. Uses scfla_pkg, scfla_ram.
`timescale 1ns / 1ps
`default_nettype none

module scfla_datapath #(
   parameter int ARENA_BYTES   = scfla_pkg::DEF_ARENA_BYTES,
   parameter int REFILL_CHUNKS = scfla_pkg::DEF_REFILL_CHUNKS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_mode,
   input  wire logic [15:0]              req_size,
   input  wire logic [15:0]              req_addr,
   input  wire scfla_pkg::ctrl_cmd_type   cmd,
   output scfla_pkg::dp_status_type       st,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [15:0]              rsp_granted,
   output logic      [1:0]               rsp_status
);

   localparam int ARENA_LIMIT = (ARENA_BYTES < scfla_pkg::ADDR_SPACE) ?
                                ARENA_BYTES : scfla_pkg::ADDR_SPACE;
   localparam logic [17:0] LIMIT  = 18'(ARENA_LIMIT);
   localparam int          CNT_W  = (REFILL_CHUNKS > 1) ? $clog2(REFILL_CHUNKS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REFILL_CHUNKS - 1);
   localparam bit          SINGLE = (REFILL_CHUNKS == 1);
   localparam int          LW     = scfla_pkg::LINK_W;
   localparam int          AW     = scfla_pkg::LINK_AW;

   logic                  mode_ff;
   logic [15:0]           size_ff;
   logic [15:0]           addr_ff;
   logic [LW-1:0]         heads_ff [scfla_pkg::NUM_CLASSES];
   logic [LW-1:0]         heads_in [scfla_pkg::NUM_CLASSES];
   logic [LW-1:0]         bump_ff;
   logic [LW-1:0]         bump_in;
   logic [LW-1:0]         wptr_ff;
   logic [LW-1:0]         wptr_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   logic [15:0]           pend_addr_ff;
   logic [1:0]            pend_status_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [15:0]           rsp_granted_ff;
   logic [1:0]            rsp_status_ff;

   logic [scfla_pkg::CLASS_W-1:0] cls;
   logic [7:0]            chunk;
   logic [17:0]           need;
   logic [17:0]           bump_sum;
   logic [LW-1:0]         head_sel;
   logic                  size_zero;
   logic                  size_over;
   logic                  pooled;
   logic                  is_free;
   logic                  has_room;
   logic [15:0]           free_addr;
   logic [15:0]           exec_addr;
   scfla_pkg::status_type exec_status;
   logic                  last_write;
   logic [LW-1:0]         refill_head;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [LW-1:0]         ram_wr_data;
   logic [LW-1:0]         ram_rd_data;

   assign cls        = scfla_pkg::class_of(size_ff);
   assign chunk      = scfla_pkg::CHUNK_MIN << cls;
   assign need       = 18'(REFILL_CHUNKS) << (cls + 3'd2);
   assign bump_sum   = {1'b0, bump_ff} + need;
   assign has_room   = bump_sum <= LIMIT;
   assign head_sel   = heads_ff[cls];
   assign size_zero  = size_ff == 16'd0;
   assign size_over  = size_ff > scfla_pkg::MAX_POOLED;
   assign pooled     = !size_zero && !size_over;
   assign is_free    = mode_ff == scfla_pkg::MODE_FREE;
   assign free_addr  = {addr_ff[15:2], 2'b00};
   assign last_write = cnt_ff == CNT_LAST;
   assign refill_head = SINGLE ? scfla_pkg::EMPTY_MARK : bump_ff + LW'(chunk);

   assign st.do_push     = pooled && is_free;
   assign st.do_pop      = pooled && !is_free && !head_sel[LW-1];
   assign st.do_refill   = pooled && !is_free && head_sel[LW-1] && has_room;
   assign st.refill_last = last_write;
   assign st.slot_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      exec_addr   = 16'd0;
      exec_status = scfla_pkg::RS_OK;
      priority if (size_zero) begin
         exec_status = scfla_pkg::RS_IGNORED;
      end else if (size_over) begin
         exec_status = scfla_pkg::RS_NOT_POOLED;
      end else if (is_free) begin
         exec_status = scfla_pkg::RS_OK;
      end else if (!head_sel[LW-1]) begin
         exec_addr = head_sel[15:0];
      end else if (has_room) begin
         exec_addr = bump_ff[15:0];
      end else begin
         exec_status = scfla_pkg::RS_EXHAUSTED;
      end
   end

   always_comb begin
      heads_in = heads_ff;
      bump_in  = bump_ff;
      priority if (cmd.push) begin
         heads_in[cls] = {1'b0, free_addr};
      end else if (cmd.pop_commit) begin
         heads_in[cls] = ram_rd_data;
      end else if (cmd.refill_commit) begin
         heads_in[cls] = refill_head;
         bump_in       = bump_sum[LW-1:0];
      end else begin
         heads_in = heads_ff;
      end
   end

   always_comb begin
      wptr_in = wptr_ff;
      cnt_in  = cnt_ff;
      if (cmd.refill_start) begin
         wptr_in = bump_ff;
         cnt_in  = '0;
      end else if (cmd.refill_write) begin
         wptr_in = wptr_ff + LW'(chunk);
         cnt_in  = cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      ram_wr_en   = cmd.push || cmd.refill_write;
      ram_wr_addr = free_addr[AW+1:2];
      ram_wr_data = head_sel;
      if (cmd.refill_write) begin
         ram_wr_addr = wptr_ff[AW+1:2];
         ram_wr_data = last_write ? scfla_pkg::EMPTY_MARK : wptr_ff + LW'(chunk);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scfla_pkg::NUM_CLASSES; i++) begin
            heads_ff[i] <= scfla_pkg::EMPTY_MARK;
         end
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         heads_ff     <= heads_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         mode_ff <= req_mode;
         size_ff <= req_size;
         addr_ff <= req_addr;
      end
      if (cmd.latch_pend) begin
         pend_addr_ff   <= exec_addr;
         pend_status_ff <= exec_status;
      end
      if (cmd.load_rsp) begin
         rsp_granted_ff <= cmd.load_src_exec ? exec_addr : pend_addr_ff;
         rsp_status_ff  <= cmd.load_src_exec ? exec_status : pend_status_ff;
      end
      wptr_ff <= wptr_in;
      cnt_ff  <= cnt_in;
   end

   scfla_ram #(
      .WIDTH(LW),
      .DEPTH(scfla_pkg::LINK_DEPTH)
   ) u_link_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.pop_read),
      .rd_addr(head_sel[AW+1:2]),
      .rd_data(ram_rd_data)
   );

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

FILE: design/size_class_free_list_allocator_unit.sv
// Top level of the size class free list allocator.
// Joins scfla_ctrl and scfla_datapath; types from scfla_pkg.
//
//   channel | direction | tdata                                 | tuser
//   req     | in        | [15:0] request_size, [31:16] chunk_address | [0] mode
//   rsp     | out       | [15:0] granted_address                | [1:0] status
//
// Free, zero size, oversize and exhausted transactions finish in the execute state;
// a pop adds the pop state for the registered read of the link store; a refill adds
// the refill state, one link write per cycle through the single write port.
// Reset: class heads empty, bump pointer zero; the link store is not cleared.
// Stalls: the result waits in an output register while the next transaction
// is accepted; the controller holds a finished result until that register frees.
`timescale 1ns / 1ps
`default_nettype none

module size_class_free_list_allocator_unit #(
   parameter int ARENA_BYTES   = scfla_pkg::DEF_ARENA_BYTES,
   parameter int REFILL_CHUNKS = scfla_pkg::DEF_REFILL_CHUNKS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] request_size, [31:16] chunk_address
   input  wire logic [0:0]  req_tuser,   // [0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [15:0] granted_address
   output logic      [1:0]  rsp_tuser    // [1:0] status
);

   scfla_pkg::ctrl_cmd_type  cmd;
   scfla_pkg::dp_status_type st;

   scfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   scfla_datapath #(
      .ARENA_BYTES  (ARENA_BYTES),
      .REFILL_CHUNKS(REFILL_CHUNKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_mode   (req_tuser[0]),
      .req_size   (req_tdata[15:0]),
      .req_addr   (req_tdata[31:16]),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_granted(rsp_tdata),
      .rsp_status (rsp_tuser)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("transaction accepted while another is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over an untaken result");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.refill_write))
      else $error("push and refill write in the same cycle");

endmodule

`default_nettype wire

FILE: dv/free_list_checker.sv
// Checker for the size class free list allocator: watches both stream channels,
// predicts each response from its own copy of the class heads, links and bump pointer.
// Depends on scfla_pkg for the mode and status codes and the store sizes.
`timescale 1ns / 1ps

module free_list_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] request_size, [31:16] chunk_address
   input  wire logic [0:0]  req_tuser,   // [0] mode
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // [15:0] granted_address
   input  wire logic [1:0]  rsp_tuser,   // [1:0] status
   output int               failures,
   output int               outstanding
);

   localparam int ARENA_TOP = (scfla_pkg::DEF_ARENA_BYTES < scfla_pkg::ADDR_SPACE) ?
                              scfla_pkg::DEF_ARENA_BYTES : scfla_pkg::ADDR_SPACE;

   typedef struct packed {
      logic [15:0]           address;
      scfla_pkg::status_type status;
   } grant_type;

   logic [scfla_pkg::LINK_W-1:0] heads [scfla_pkg::NUM_CLASSES];
   logic [scfla_pkg::LINK_W-1:0] bump;
   logic [scfla_pkg::LINK_W-1:0] links [scfla_pkg::LINK_DEPTH];
   grant_type                    grants_due [$];

   function automatic int size_class(input logic [15:0] size);
      int c;
      c = 0;
      while (c < scfla_pkg::NUM_CLASSES - 1 && (4 << c) < size) c++;
      return c;
   endfunction

   function automatic grant_type allocate_or_free(input scfla_pkg::mode_type mode,
                                                  input logic [15:0] size,
                                                  input logic [15:0] addr);
      grant_type   r;
      int          c;
      int          chunk;
      int          need;
      int          base;
      int          i;
      logic [15:0] a;
      r.address = '0;
      r.status  = scfla_pkg::RS_OK;
      if (size == 16'd0) begin
         r.status = scfla_pkg::RS_IGNORED;
      end else if (size > scfla_pkg::MAX_POOLED) begin
         r.status = scfla_pkg::RS_NOT_POOLED;
      end else begin
         c     = size_class(size);
         chunk = 4 << c;
         if (mode == scfla_pkg::MODE_FREE) begin
            a = addr & 16'hFFFC;
            links[a[15:2]] = heads[c];
            heads[c] = {1'b0, a};
         end else if (!heads[c][16]) begin
            r.address = heads[c][15:0];
            heads[c]  = links[heads[c][15:2]];
         end else begin
            need = chunk * scfla_pkg::DEF_REFILL_CHUNKS;
            base = int'(bump);
            if (base > ARENA_TOP || need > ARENA_TOP - base) begin
               r.status = scfla_pkg::RS_EXHAUSTED;
            end else begin
               for (i = 0; i < scfla_pkg::DEF_REFILL_CHUNKS - 1; i++)
                  links[((base + i * chunk) / 4) % scfla_pkg::LINK_DEPTH] =
                     scfla_pkg::LINK_W'(base + (i + 1) * chunk);
               links[((base + i * chunk) / 4) % scfla_pkg::LINK_DEPTH] = scfla_pkg::EMPTY_MARK;
               bump      = scfla_pkg::LINK_W'(base + need);
               r.address = base[15:0];
               heads[c]  = links[(base / 4) % scfla_pkg::LINK_DEPTH];
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         for (int c = 0; c < scfla_pkg::NUM_CLASSES; c++) heads[c] = scfla_pkg::EMPTY_MARK;
         bump = '0;
         grants_due.delete();
         failures    = 0;
         outstanding = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (grants_due.size() == 0) begin
               failures++;
               $error("unexpected transaction: granted_address %h, status %0d",
                      rsp_tdata, rsp_tuser);
            end else begin
               want = grants_due.pop_front();
               if (rsp_tdata !== want.address) begin
                  failures++;
                  $error("granted_address: expected %h, actual %h", want.address, rsp_tdata);
               end
               if (rsp_tuser !== want.status) begin
                  failures++;
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready)
            grants_due.push_back(allocate_or_free(scfla_pkg::mode_type'(req_tuser[0]),
                                                  req_tdata[15:0], req_tdata[31:16]));
         outstanding = grants_due.size();
      end
   end

endmodule

FILE: dv/tb.sv
// Top of the allocator testbench: clock, reset, request traffic and response back-pressure.
// Instantiates size_class_free_list_allocator_unit and free_list_checker; uses scfla_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      scfla_pkg::mode_type mode;
      logic [15:0]         size;
   } sent_type;

   typedef struct packed {
      logic [15:0] address;
      logic [15:0] size;
   } held_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int       failures;
   int       outstanding;
   int       idle_pct      = 0;
   int       stall_left    = 0;
   int       cycles        = 0;
   bit       saw_exhausted = 1'b0;
   sent_type in_flight [$];
   held_type owned [$];

   size_class_free_list_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   free_list_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // track granted chunks so later frees return them to the right class
   always @(posedge clock) begin
      sent_type s;
      if (!reset && rsp_tvalid && rsp_tready && in_flight.size() > 0) begin
         s = in_flight.pop_front();
         if (rsp_tuser == scfla_pkg::RS_EXHAUSTED) saw_exhausted = 1'b1;
         if (s.mode == scfla_pkg::MODE_ALLOC && rsp_tuser == scfla_pkg::RS_OK)
            owned.push_back('{rsp_tdata, s.size});
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 3) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send(input scfla_pkg::mode_type mode, input logic [15:0] size,
                       input logic [15:0] addr);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {addr, size};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      in_flight.push_back('{mode, size});
      @(negedge clock);
   endtask

   // hold the request channel until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic random_item(input bit greedy);
      held_type    h;
      logic [15:0] size;
      int          pick;
      int          k;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         send(scfla_pkg::mode_type'($urandom_range(0, 1)), 16'd0, 16'($urandom()));
      end else if (pick < 7) begin
         send(scfla_pkg::mode_type'($urandom_range(0, 1)), 16'($urandom_range(129, 65535)),
              16'($urandom()));
      end else if (owned.size() > 0 && $urandom_range(0, 99) < (greedy ? 5 : 45)) begin
         k = $urandom_range(0, owned.size() - 1);
         h = owned[k];
         owned.delete(k);
         send(scfla_pkg::MODE_FREE, h.size, h.address);
      end else if ($urandom_range(0, 99) < 8) begin
         send(scfla_pkg::MODE_FREE, 16'($urandom_range(1, 128)), 16'($urandom()));
      end else begin
         if (greedy && $urandom_range(0, 99) < 85)
            size = 16'($urandom_range(65, 128));
         else if ($urandom_range(0, 2) == 0)
            size = 16'(4 << $urandom_range(0, 5));
         else
            size = 16'($urandom_range(1, 128));
         send(scfla_pkg::MODE_ALLOC, size, 16'($urandom()));
      end
   endtask

   initial begin
      int blk;
      int n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 20;

      send(scfla_pkg::MODE_ALLOC, 16'd0, 16'h1234);
      send(scfla_pkg::MODE_FREE, 16'd0, 16'hFFFF);
      send(scfla_pkg::MODE_ALLOC, 16'd129, 16'h0000);
      send(scfla_pkg::MODE_FREE, 16'hFFFF, 16'hFFFF);
      send(scfla_pkg::MODE_ALLOC, 16'd1, 16'hFFFF);
      send(scfla_pkg::MODE_ALLOC, 16'd4, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd5, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd8, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd9, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd16, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd17, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd32, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd33, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd64, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd65, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd128, 16'h0000);
      send(scfla_pkg::MODE_FREE, 16'd4, 16'hFFFF);
      send(scfla_pkg::MODE_ALLOC, 16'd3, 16'h0000);
      send(scfla_pkg::MODE_FREE, 16'd128, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd100, 16'h0000);
      send(scfla_pkg::MODE_FREE, 16'd1, 16'h0002);
      send(scfla_pkg::MODE_FREE, 16'd1, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd2, 16'h0000);
      send(scfla_pkg::MODE_ALLOC, 16'd2, 16'h0000);
      drain();

      for (blk = 0; blk < 10; blk++) begin
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
         endcase
         if (blk == 9) idle_pct = 0;
         for (n = 0; n < 200; n++) random_item(blk >= 4 && !saw_exhausted);
         if (blk == 3) drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
